// ----- design/mstg_pkg.sv -----
// Shared beat types, stream entry layout and function codes for the taus88 stream bank.
package mstg_pkg;

    localparam logic [1:0] FUNC_DRAW = 2'd0;
    localparam logic [1:0] FUNC_LOAD = 2'd1;
    localparam logic [1:0] FUNC_PEEK = 2'd2;

    localparam int IDX_W = 9;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  stream;
        logic [31:0] seed_first;
        logic [31:0] seed_second;
        logic [31:0] seed_third;
        logic [31:0] range_low;
        logic [31:0] range_high;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] raw_value;
        logic [31:0] scaled_value;
    } t_out_beat;

    typedef struct packed {
        logic [31:0] last_output;
        logic [31:0] word_third;
        logic [31:0] word_second;
        logic [31:0] word_first;
    } t_entry;

    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_addr;
    } t_bank_wr;

endpackage

// ----- design/mstg_bank.sv -----
// Stream state memory with registered read and per-entry valid bits.
module mstg_bank
    import mstg_pkg::*;
#(
    parameter int NUM_STREAMS = 16,
    parameter int AW          = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry                   mem [NUM_STREAMS];
    logic [NUM_STREAMS-1:0]   r_valid;
    t_entry                   r_rd_data;
    logic                     r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // Entries never written since reset read as zero.
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ----- design/multi_stream_taus88_generator.sv -----
// Top level of the multi-stream taus88 generator with draw, seed load and peek.
// Each beat runs in order: the accept edge issues the state memory read, the
// next cycle (ST_READ) writes the entry back with the three Tausworthe words
// advanced for a draw or with the seeds for a load, then ST_MULT forms the 32x32
// product of the raw word and the span and ST_FINAL divides it by 2^32-1 and,
// for a draw, adds the lower bound. The result beat is shown on o_result with
// o_strobe as a one-cycle strobe in the cycle after ST_FINAL, when busy is
// already low so the next beat can be started; the receiver cannot stall. A
// new beat is accepted only after the previous one has left ST_FINAL. All
// streams read as zero after reset without any clearing pass.
module multi_stream_taus88_generator
    import mstg_pkg::*;
#(
    parameter int NUM_STREAMS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_beat  i_in,
    output logic      o_strobe,
    output t_out_beat o_result
);

    localparam int AW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_MULT  = 4'b0100,
        ST_FINAL = 4'b1000
    } t_state;

    t_state        r_state;
    logic [1:0]    r_func;
    logic          r_ok;
    logic [AW-1:0] r_addr;
    logic [31:0]   r_seed_first;
    logic [31:0]   r_seed_second;
    logic [31:0]   r_seed_third;
    logic [31:0]   r_lo;
    logic [31:0]   r_span;
    logic [31:0]   r_raw;
    logic          r_draw;
    logic [63:0]   r_prod;
    logic          r_strobe;
    t_out_beat     r_result;

    logic          accept;
    logic [IDX_W-1:0] idx_wide;
    t_entry        rd_data;
    t_entry        nxt;
    t_entry        wr_data;
    t_bank_wr      bank_wr;
    logic [31:0]   n_raw;
    logic [31:0]   prod_hi;
    logic [31:0]   prod_lo;
    logic [32:0]   sum_hl;
    logic [32:0]   sum_fix;
    logic [1:0]    adj;
    logic [31:0]   quot;

    function automatic t_entry taus_step(input t_entry cur);
        t_entry      res;
        logic [31:0] fb;
        begin
            res = cur;
            fb = ((cur.word_first << 13) ^ cur.word_first) >> 19;
            res.word_first = ((cur.word_first & 32'hFFFFFFFE) << 12) ^ fb;
            fb = ((cur.word_second << 2) ^ cur.word_second) >> 25;
            res.word_second = ((cur.word_second & 32'hFFFFFFF8) << 4) ^ fb;
            fb = ((cur.word_third << 3) ^ cur.word_third) >> 11;
            res.word_third = ((cur.word_third & 32'hFFFFFFF0) << 17) ^ fb;
            res.last_output = res.word_first ^ res.word_second ^ res.word_third;
            return res;
        end
    endfunction

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign idx_wide = IDX_W'(i_in.stream);

    mstg_bank #(
        .NUM_STREAMS (NUM_STREAMS),
        .AW          (AW)
    ) u_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (idx_wide[AW-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (bank_wr.wr_en),
        .i_wr_addr (bank_wr.wr_addr[AW-1:0]),
        .i_wr_data (wr_data)
    );

    always_comb begin
        nxt             = taus_step(rd_data);
        bank_wr.wr_en   = 1'b0;
        bank_wr.wr_addr = 8'(r_addr);
        wr_data         = nxt;
        n_raw           = '0;
        if ((r_state == ST_READ) && r_ok) begin
            case (r_func)
                FUNC_DRAW: begin
                    bank_wr.wr_en = 1'b1;
                    n_raw         = nxt.last_output;
                end
                FUNC_LOAD: begin
                    bank_wr.wr_en       = 1'b1;
                    wr_data.last_output = rd_data.last_output;
                    wr_data.word_first  = r_seed_first;
                    wr_data.word_second = r_seed_second;
                    wr_data.word_third  = r_seed_third;
                end
                FUNC_PEEK: begin
                    n_raw = rd_data.last_output;
                end
                default: begin
                    n_raw = '0;
                end
            endcase
        end
    end

    // Exact floor(P / (2^32-1)) with P = H*2^32 + L: H plus floor((H+L) / (2^32-1)).
    always_comb begin
        prod_hi = r_prod[63:32];
        prod_lo = r_prod[31:0];
        sum_hl  = {1'b0, prod_hi} + {1'b0, prod_lo};
        sum_fix = {1'b0, sum_hl[31:0]} + {32'b0, sum_hl[32]};
        adj     = {1'b0, sum_hl[32]} + {1'b0, (sum_fix >= 33'h0FFFFFFFF)};
        quot    = prod_hi + {30'b0, adj};
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func        <= i_in.func;
            r_addr        <= idx_wide[AW-1:0];
            r_seed_first  <= i_in.seed_first;
            r_seed_second <= i_in.seed_second;
            r_seed_third  <= i_in.seed_third;
            r_lo          <= i_in.range_low;
            r_span        <= i_in.range_high - i_in.range_low;
        end
        if (r_state == ST_READ) begin
            r_raw  <= n_raw;
            r_draw <= r_ok && (r_func == FUNC_DRAW);
        end
        if (r_state == ST_MULT) begin
            r_prod <= {32'b0, r_raw} * {32'b0, r_span};
        end
        if (r_state == ST_FINAL) begin
            r_result.raw_value    <= r_raw;
            r_result.scaled_value <= r_draw ? (r_lo + quot) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ok     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_ok    <= (idx_wide < IDX_W'(NUM_STREAMS));
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_MULT;
                end
                ST_MULT: begin
                    r_state <= ST_FINAL;
                end
                ST_FINAL: begin
                    r_strobe <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
